[src/ajb_pkg.sv]
// shared types and constants for the audio jitter buffer
`default_nettype none
package ajb_pkg;

  localparam int RING_DEPTH  = 16384;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int LVL_W       = 14;
  localparam int CMP_W       = (PTR_W > LVL_W) ? PTR_W : LVL_W;
  localparam int SAMPLE_W    = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  localparam logic [LVL_W-1:0] RESET_START  = LVL_W'(3840);
  localparam logic [LVL_W-1:0] RESET_HIGH   = LVL_W'(9600);
  localparam logic [LVL_W-1:0] RESET_TARGET = LVL_W'(4800);

  typedef logic [PTR_W-1:0]           ptr_t;
  typedef logic [LVL_W-1:0]           lvl_t;
  typedef logic [CMP_W-1:0]           cmp_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_PULL = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    REG_START_LEVEL  = 2'd0,
    REG_HIGH_WATER   = 2'd1,
    REG_TARGET_LEVEL = 2'd2
  } reg_idx_t;

  typedef struct packed {
    lvl_t start_level;
    lvl_t high_water_level;
    lvl_t target_level;
  } cfg_t;

  typedef struct packed {
    logic    wr_en;
    logic    rd_en;
    ptr_t    addr;
    sample_t sample;
    lvl_t    fill;
    logic    playing;
    logic    underrun;
    logic    dropped;
  } cmd_t;

endpackage
`default_nettype wire

[src/ajb_regs.sv]
// level registers behind the apb port
`default_nettype none
module ajb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [ajb_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [ajb_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [ajb_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output ajb_pkg::cfg_t                         cfg
);

  logic         wr_stb;
  logic [1:0]   idx;
  ajb_pkg::lvl_t rd_val;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_level      <= ajb_pkg::RESET_START;
      cfg.high_water_level <= ajb_pkg::RESET_HIGH;
      cfg.target_level     <= ajb_pkg::RESET_TARGET;
    end else if (wr_stb) begin
      unique case (idx)
        ajb_pkg::REG_START_LEVEL:  cfg.start_level      <= pwdata[ajb_pkg::LVL_W-1:0];
        ajb_pkg::REG_HIGH_WATER:   cfg.high_water_level <= pwdata[ajb_pkg::LVL_W-1:0];
        ajb_pkg::REG_TARGET_LEVEL: cfg.target_level     <= pwdata[ajb_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ajb_pkg::REG_START_LEVEL:  rd_val = cfg.start_level;
      ajb_pkg::REG_HIGH_WATER:   rd_val = cfg.high_water_level;
      ajb_pkg::REG_TARGET_LEVEL: rd_val = cfg.target_level;
      default:                   rd_val = '0;
    endcase
    prdata = ajb_pkg::APB_DATA_W'(rd_val);
  end

endmodule
`default_nettype wire

[src/ajb_front.sv]
// request classification: pointers, play state and level checks
`default_nettype none
module ajb_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          req_type,
  input  wire logic signed [ajb_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                          first_of_group,
  input  wire logic [ajb_pkg::LVL_W-1:0]     burst_len,
  input  ajb_pkg::cfg_t                      cfg,
  input  wire logic                          q_full,
  output logic                               q_push,
  output ajb_pkg::cmd_t                      cmd
);

  ajb_pkg::ptr_t write_ptr, write_ptr_next;
  ajb_pkg::ptr_t read_ptr, read_ptr_next;
  logic          play_enable, play_enable_next;
  logic          burst_silent, burst_silent_next;
  ajb_pkg::ptr_t fill_now;
  ajb_pkg::ptr_t fill_after;
  ajb_pkg::cmp_t avail_c, start_c, high_c, target_c, blen_c;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    fill_now = write_ptr - read_ptr;
    avail_c  = ajb_pkg::cmp_t'(fill_now);
    start_c  = ajb_pkg::cmp_t'(cfg.start_level);
    high_c   = ajb_pkg::cmp_t'(cfg.high_water_level);
    target_c = ajb_pkg::cmp_t'(cfg.target_level);
    blen_c   = ajb_pkg::cmp_t'(burst_len);

    write_ptr_next    = write_ptr;
    read_ptr_next     = read_ptr;
    play_enable_next  = play_enable;
    burst_silent_next = burst_silent;

    cmd          = '0;
    cmd.sample   = in_sample;

    if (req_type == ajb_pkg::REQ_PUSH) begin
      if (first_of_group) begin
        if (avail_c > high_c && target_c < avail_c) begin
          read_ptr_next = write_ptr - ajb_pkg::ptr_t'(target_c);
          cmd.dropped   = 1'b1;
        end
        if (!play_enable && avail_c >= start_c) begin
          play_enable_next = 1'b1;
        end
      end
      cmd.wr_en      = 1'b1;
      cmd.addr       = write_ptr;
      write_ptr_next = write_ptr + ajb_pkg::ptr_t'(1);
    end else begin
      if (first_of_group) begin
        if (!play_enable) begin
          burst_silent_next = 1'b1;
        end else if (avail_c < blen_c) begin
          burst_silent_next = 1'b1;
          play_enable_next  = 1'b0;
          cmd.underrun      = 1'b1;
        end else begin
          burst_silent_next = 1'b0;
        end
      end
      if (!burst_silent_next && fill_now != '0) begin
        cmd.rd_en     = 1'b1;
        cmd.addr      = read_ptr;
        read_ptr_next = read_ptr + ajb_pkg::ptr_t'(1);
      end
    end

    fill_after  = write_ptr_next - read_ptr_next;
    cmd.fill    = ajb_pkg::lvl_t'(fill_after);
    cmd.playing = play_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr    <= '0;
      read_ptr     <= '0;
      play_enable  <= 1'b0;
      burst_silent <= 1'b0;
    end else if (q_push) begin
      write_ptr    <= write_ptr_next;
      read_ptr     <= read_ptr_next;
      play_enable  <= play_enable_next;
      burst_silent <= burst_silent_next;
    end
  end

endmodule
`default_nettype wire

[src/ajb_cmd_queue.sv]
// short command queue between front and back
`default_nettype none
module ajb_cmd_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  ajb_pkg::cmd_t wr_cmd,
  output logic          full,
  input  wire logic     rd,
  output ajb_pkg::cmd_t rd_cmd,
  output logic          empty
);

  ajb_pkg::cmd_t                entries [ajb_pkg::QUEUE_DEPTH];
  logic [ajb_pkg::QPTR_W-1:0]   wptr;
  logic [ajb_pkg::QPTR_W-1:0]   rptr;
  logic [ajb_pkg::QPTR_W:0]     count;

  assign full   = (count == (ajb_pkg::QPTR_W+1)'(ajb_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + ajb_pkg::QPTR_W'(1);
      end
      if (rd) begin
        rptr <= rptr + ajb_pkg::QPTR_W'(1);
      end
      if (wr && !rd) begin
        count <= count + (ajb_pkg::QPTR_W+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (ajb_pkg::QPTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

[src/ajb_back.sv]
// ring memory access and result register
`default_nettype none
module ajb_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  ajb_pkg::cmd_t                      cmd,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [ajb_pkg::SAMPLE_W-1:0] out_sample,
  output logic [ajb_pkg::LVL_W-1:0]          fill_level,
  output logic                               playing,
  output logic                               underrun,
  output logic                               dropped
);

  ajb_pkg::sample_t ring [ajb_pkg::RING_DEPTH];
  ajb_pkg::sample_t rdata;
  ajb_pkg::cmd_t    s1_cmd;
  logic             s1_valid;
  logic             out_valid;
  logic             out_ready;
  logic             s1_ready;

  assign out_ready = !out_valid || pop;
  assign s1_ready  = !s1_valid || out_ready;
  assign q_pop     = !q_empty && s1_ready;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (q_pop && cmd.wr_en) begin
      ring[cmd.addr] <= cmd.sample;
    end
    if (q_pop && cmd.rd_en) begin
      rdata <= ring[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd <= cmd;
    end
    if (out_ready && s1_valid) begin
      out_sample <= s1_cmd.rd_en ? rdata : '0;
      fill_level <= s1_cmd.fill;
      playing    <= s1_cmd.playing;
      underrun   <= s1_cmd.underrun;
      dropped    <= s1_cmd.dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_pop;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule
`default_nettype wire

[src/audio_jitter_buffer_core.sv]
// audio jitter buffer top level: ring of 16-bit samples between a push and a pull side
// requests enter through a queue-style port: push with full, each carrying req_type
// (push one sample or pull one sample), in_sample, first_of_group and burst_len.
// results leave through a queue-style port: empty with pop; every request gives
// exactly one result (out_sample, fill_level, playing, underrun, dropped), in order.
// the front stage classifies a request in its accept cycle: level checks, drop,
// play and burst state, ring pointers. a four-entry command queue sits between
// it and the back stage, which owns the 16384-entry ring memory (one port, one
// access per request) and a two-register output pipeline.
// a result is registered in the command queue, then stage one, then the output stage.
// throughput: one request per cycle while pop is held high; set by the single
// memory access per request.
// when the receiver stalls, results build up in the output stages and the queue;
// full rises once the queue holds four requests and requests are held off without loss.
// reset (synchronous, rst high) clears the pointers, play and burst state and all
// queues, and loads the level registers with their defaults; the ring memory is
// not cleared and is only read where it has been written.
// level registers sit on the apb port at byte offsets 0, 4 and 8.
`default_nettype none
module audio_jitter_buffer_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [ajb_pkg::APB_ADDR_W-1:0]       paddr,
  input  wire logic [ajb_pkg::APB_DATA_W-1:0]       pwdata,
  output logic      [ajb_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                      pready,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic                                 req_type,
  input  wire logic signed [ajb_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic                                 first_of_group,
  input  wire logic [ajb_pkg::LVL_W-1:0]            burst_len,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [ajb_pkg::SAMPLE_W-1:0]       out_sample,
  output logic [ajb_pkg::LVL_W-1:0]                 fill_level,
  output logic                                      playing,
  output logic                                      underrun,
  output logic                                      dropped
);

  ajb_pkg::cfg_t cfg;
  ajb_pkg::cmd_t front_cmd;
  ajb_pkg::cmd_t back_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  ajb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ajb_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (req_type),
    .in_sample      (in_sample),
    .first_of_group (first_of_group),
    .burst_len      (burst_len),
    .cfg            (cfg),
    .q_full         (q_full),
    .q_push         (q_push),
    .cmd            (front_cmd)
  );

  ajb_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .rd     (q_pop),
    .rd_cmd (back_cmd),
    .empty  (q_empty)
  );

  ajb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (back_cmd),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_sample (out_sample),
    .fill_level (fill_level),
    .playing    (playing),
    .underrun   (underrun),
    .dropped    (dropped)
  );

endmodule
`default_nettype wire
